[hw/rtl/pbmm_pkg.sv]
// ----------------------------------------------------------------------------
// pbmm_pkg
// Shared widths, constants and word types of the point/box distance unit.
// ----------------------------------------------------------------------------
package pbmm_pkg;

	localparam int COORD_W     = 16;
	localparam int SQ_W        = 2 * COORD_W;
	localparam int SUM_W       = 36;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int REM_W       = ROOT_W + 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 144;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] max_sq;
		logic [SUM_W-1:0] min_sq;
		logic [COORD_W-1:0] near_c;
		logic [COORD_W-1:0] far_c;
	} entry_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] max_dist;
		logic [ROOT_W-1:0] min_dist;
		logic [SUM_W-1:0]  max_sq;
		logic [SUM_W-1:0]  min_sq;
		logic [COORD_W-1:0] near_c;
		logic [COORD_W-1:0] far_c;
	} res_t;

endpackage

[hw/rtl/point_box_min_max_distance_unit.sv]
// Each word passes front stages s1 and s2 and the queue to the output register.
// Throughput: one dimension word per cycle while no last dimension is pending
// and the output is not stalled; a last-dimension word holds the back end for 18 serial root steps.
// A 4-word queue lets the front keep taking words while the back end works.
// Reset (arst_n low, asynchronous) clears the running sums, queue and valids.
// ----------------------------------------------------------------------------
// point_box_min_max_distance_unit
// Nearest/farthest point-to-box distance, one dimension per word.
// ----------------------------------------------------------------------------
module point_box_min_max_distance_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// box_low [15:0], box_high [31:16], point_coord [47:32]
	input  logic [pbmm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// far_coord [15:0], near_coord [31:16], min_dist_sq [67:32],
	// max_dist_sq [103:68], min_dist [121:104], max_dist [139:122], zero pad
	output logic [pbmm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast
);

	localparam int CW = pbmm_pkg::COORD_W;

	logic             q_push, q_ready, q_valid, q_pop;
	pbmm_pkg::entry_t q_wdata, q_rdata;
	pbmm_pkg::res_t   res;

	pbmm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_low(s_axis_tdata[CW-1:0]),
		.in_high(s_axis_tdata[2*CW-1:CW]),
		.in_coord(s_axis_tdata[3*CW-1:2*CW]),
		.in_last(s_axis_tlast),
		.q_push(q_push), .q_ready(q_ready), .q_data(q_wdata)
	);

	pbmm_fifo u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata(q_wdata), .ready(q_ready),
		.pop(q_pop), .valid(q_valid), .rdata(q_rdata)
	);

	pbmm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_rdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = {4'b0000, res.max_dist, res.min_dist, res.max_sq, res.min_sq,
		res.near_c, res.far_c};
	assign m_axis_tlast = res.done;

endmodule

[hw/rtl/pbmm_front.sv]
// ----------------------------------------------------------------------------
// pbmm_front
// Classifies each dimension, squares the gaps and keeps the running sums.
// ----------------------------------------------------------------------------
module pbmm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [pbmm_pkg::COORD_W-1:0] in_low,
	input  logic signed [pbmm_pkg::COORD_W-1:0] in_high,
	input  logic signed [pbmm_pkg::COORD_W-1:0] in_coord,
	input  logic                              in_last,
	output logic                              q_push,
	input  logic                              q_ready,
	output pbmm_pkg::entry_t                  q_data
);

	localparam int CW = pbmm_pkg::COORD_W;
	localparam int SW = pbmm_pkg::SUM_W;
	localparam int QW = pbmm_pkg::SQ_W;

	logic signed [CW:0] d_lo, d_hi, twice_x, lo_plus_hi;
	logic [CW-1:0]      a_lo, a_hi, gmin, gmax;
	logic [CW-1:0]      far_c, near_c;
	logic               le_lo, ge_hi, below_mid;
	logic               en1, en2;

	logic               v_s1, last_s1, v_s2, last_s2;
	logic [CW-1:0]      gmin_s1, gmax_s1, far_s1, near_s1, far_s2, near_s2;
	logic [QW-1:0]      sqmin_s2, sqmax_s2;
	logic [SW-1:0]      min_sum_q, max_sum_q;
	logic [SW:0]        min_add, max_add;
	logic [SW-1:0]      min_new, max_new;

	assign d_lo       = {in_low[CW-1], in_low} - {in_coord[CW-1], in_coord};
	assign d_hi       = {in_high[CW-1], in_high} - {in_coord[CW-1], in_coord};
	assign twice_x    = {in_coord, 1'b0};
	assign lo_plus_hi = {in_low[CW-1], in_low} + {in_high[CW-1], in_high};
	assign a_lo       = d_lo[CW] ? CW'(-d_lo) : d_lo[CW-1:0];
	assign a_hi       = d_hi[CW] ? CW'(-d_hi) : d_hi[CW-1:0];
	assign le_lo      = in_coord <= in_low;
	assign ge_hi      = in_coord >= in_high;
	assign below_mid  = twice_x < lo_plus_hi;

	always_comb begin
		if (le_lo) begin
			gmin   = a_lo;
			gmax   = a_hi;
			far_c  = in_high;
			near_c = in_low;
		end else if (ge_hi) begin
			gmin   = a_hi;
			gmax   = a_lo;
			far_c  = in_low;
			near_c = in_high;
		end else begin
			gmin   = '0;
			near_c = in_coord;
			gmax   = below_mid ? a_hi : a_lo;
			far_c  = below_mid ? in_high : in_low;
		end
	end

	assign q_push   = v_s2 && q_ready;
	assign en2      = !v_s2 || q_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			gmin_s1 <= gmin;
			gmax_s1 <= gmax;
			far_s1  <= far_c;
			near_s1 <= near_c;
			last_s1 <= in_last;
		end
		if (en2 && v_s1) begin
			sqmin_s2 <= gmin_s1 * gmin_s1;
			sqmax_s2 <= gmax_s1 * gmax_s1;
			far_s2   <= far_s1;
			near_s2  <= near_s1;
			last_s2  <= last_s1;
		end
	end

	// saturating accumulate at push time
	assign min_add = {1'b0, min_sum_q} + (SW+1)'(sqmin_s2);
	assign max_add = {1'b0, max_sum_q} + (SW+1)'(sqmax_s2);
	assign min_new = min_add[SW] ? pbmm_pkg::SUM_MAX : min_add[SW-1:0];
	assign max_new = max_add[SW] ? pbmm_pkg::SUM_MAX : max_add[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sum_q <= '0;
			max_sum_q <= '0;
		end else if (q_push) begin
			min_sum_q <= last_s2 ? '0 : min_new;
			max_sum_q <= last_s2 ? '0 : max_new;
		end
	end

	always_comb begin
		q_data.far_c  = far_s2;
		q_data.near_c = near_s2;
		q_data.min_sq = last_s2 ? min_new : '0;
		q_data.max_sq = last_s2 ? max_new : '0;
		q_data.done   = last_s2;
	end

endmodule

[hw/rtl/pbmm_fifo.sv]
// ----------------------------------------------------------------------------
// pbmm_fifo
// Short first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
module pbmm_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pbmm_pkg::entry_t wdata,
	output logic             ready,
	input  logic             pop,
	output logic             valid,
	output pbmm_pkg::entry_t rdata
);

	localparam int PW = pbmm_pkg::QPTR_W;

	pbmm_pkg::entry_t mem_q [pbmm_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [PW:0]      count_q;

	assign ready = count_q != (PW+1)'(pbmm_pkg::QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

endmodule

[hw/rtl/pbmm_isqrt.sv]
// ----------------------------------------------------------------------------
// pbmm_isqrt
// Bit-serial floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pbmm_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pbmm_pkg::SUM_W-1:0]     rad,
	output logic                           busy,
	output logic [pbmm_pkg::ROOT_W-1:0]    root
);

	localparam int SW = pbmm_pkg::SUM_W;
	localparam int RW = pbmm_pkg::ROOT_W;
	localparam int MW = pbmm_pkg::REM_W;
	localparam int CNT_W = $clog2(RW + 1);

	logic [SW-1:0]    rad_q;
	logic [MW-1:0]    rem_q;
	logic [RW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [MW+1:0]    rem_sh, trial, diff;
	logic             ge;

	assign rem_sh = {rem_q, rad_q[SW-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;
	assign busy   = busy_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(RW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SW-3:0], 2'b00};
			rem_q  <= ge ? diff[MW-1:0] : rem_sh[MW-1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

endmodule

[hw/rtl/pbmm_back.sv]
// ----------------------------------------------------------------------------
// pbmm_back
// Drains the queue, runs the roots on last-dimension words, holds the output.
// ----------------------------------------------------------------------------
module pbmm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  pbmm_pkg::entry_t q_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pbmm_pkg::res_t   out_data
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_ROOT = 1'b1;

	logic [0:0]       state_q;
	logic             out_valid_q, out_free;
	pbmm_pkg::res_t   out_q;
	pbmm_pkg::entry_t hold_q;
	logic             start, busy_min, busy_max, load_pass, load_root;
	logic [pbmm_pkg::ROOT_W-1:0] root_min, root_max;

	assign out_free  = !out_valid_q || out_ready;
	assign load_pass = state_q == ST_IDLE && q_valid && !q_data.done && out_free;
	assign start     = state_q == ST_IDLE && q_valid && q_data.done;
	assign load_root = state_q == ST_ROOT && !busy_min && !busy_max && out_free;
	assign q_pop     = load_pass || start;

	pbmm_isqrt u_root_min (
		.clk(clk), .arst_n(arst_n), .start(start), .rad(q_data.min_sq),
		.busy(busy_min), .root(root_min)
	);

	pbmm_isqrt u_root_max (
		.clk(clk), .arst_n(arst_n), .start(start), .rad(q_data.max_sq),
		.busy(busy_max), .root(root_max)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_ROOT;
				ST_ROOT: if (load_root) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (load_pass || load_root) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) hold_q <= q_data;
		if (load_pass) begin
			out_q.far_c    <= q_data.far_c;
			out_q.near_c   <= q_data.near_c;
			out_q.min_sq   <= '0;
			out_q.max_sq   <= '0;
			out_q.min_dist <= '0;
			out_q.max_dist <= '0;
			out_q.done     <= 1'b0;
		end else if (load_root) begin
			out_q.far_c    <= hold_q.far_c;
			out_q.near_c   <= hold_q.near_c;
			out_q.min_sq   <= hold_q.min_sq;
			out_q.max_sq   <= hold_q.max_sq;
			out_q.min_dist <= root_min;
			out_q.max_dist <= root_max;
			out_q.done     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/pbmm_checker.sv]
// ----------------------------------------------------------------------------
// pbmm_checker
// Port-level checks of the distance unit's result stream.
// ----------------------------------------------------------------------------
module pbmm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [pbmm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast
);

	logic [37:0] min_sq, max_sq, rmin, rmax;

	assign min_sq = 38'(m_axis_tdata[67:32]);
	assign max_sq = 38'(m_axis_tdata[103:68]);
	assign rmin   = 38'(m_axis_tdata[121:104]);
	assign rmax   = 38'(m_axis_tdata[139:122]);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word dropped or changed under stall");

	a_inner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[143:32] == '0)
		else $error("inner dimension carries sums or roots");

	a_min_root: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			rmin * rmin <= min_sq && (rmin + 38'd1) * (rmin + 38'd1) > min_sq)
		else $error("min_dist is not the floor root");

	a_max_root: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			rmax * rmax <= max_sq && (rmax + 38'd1) * (rmax + 38'd1) > max_sq)
		else $error("max_dist is not the floor root");

endmodule

bind point_box_min_max_distance_unit pbmm_checker u_pbmm_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
